/* rtl/rqd_pkg.sv */
// Shared types and constants for the ready queue dispatcher.
// No dependencies; imported by rqd_front, rqd_back and the top level.
`timescale 1ns / 1ps
`default_nettype none

package rqd_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned ID_BITS_DEF     = 16;
  localparam int unsigned PRIO_BITS_DEF   = 8;

  // depth of the request queue between front and back
  localparam int unsigned CMDQ_DEPTH = 2;

  localparam logic [1:0] POLICY_FIFO = 2'd0;
  localparam logic [1:0] POLICY_RR   = 2'd1;
  localparam logic [1:0] POLICY_PRIO = 2'd2;

  typedef enum logic [1:0] {
    OP_ENQ     = 2'd0,
    OP_DISP    = 2'd1,
    OP_REQUEUE = 2'd2,
    OP_RETIRE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    STAT_OK    = 3'd0,
    STAT_EMPTY = 3'd1,
    STAT_FULL  = 3'd2,
    STAT_BUSY  = 3'd3,
    STAT_IDLE  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_COMPACT
  } bk_state_e;

  // request handed from the front to the back
  typedef struct packed {
    logic valid;
    op_e  op;
  } cmd_hdr_t;

endpackage : rqd_pkg

`default_nettype wire

/* rtl/rqd_front.sv */
// Front end: accepts requests, decodes the opcode and holds them in a short queue.
// Depends on rqd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rqd_front #(
  parameter int unsigned ID_BITS   = rqd_pkg::ID_BITS_DEF,
  parameter int unsigned PRIO_BITS = rqd_pkg::PRIO_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [1:0]           opcode_i,
  input  wire logic [ID_BITS-1:0]   proc_id_i,
  input  wire logic [PRIO_BITS-1:0] proc_priority_i,
  output rqd_pkg::cmd_hdr_t         cmd_hdr_o,
  input  wire logic                 cmd_ready_i,
  output logic [ID_BITS-1:0]        cmd_id_o,
  output logic [PRIO_BITS-1:0]      cmd_prio_o
);
  import rqd_pkg::*;

  localparam int unsigned AW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int unsigned CW = $clog2(CMDQ_DEPTH + 1);

  op_e                 op_q   [CMDQ_DEPTH];
  logic [ID_BITS-1:0]  id_q   [CMDQ_DEPTH];
  logic [PRIO_BITS-1:0] prio_q [CMDQ_DEPTH];

  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          push, pop;

  assign in_ready_o = (cnt_q != CW'(CMDQ_DEPTH));
  assign push       = in_valid_i && in_ready_o;
  assign pop        = cmd_hdr_o.valid && cmd_ready_i;

  assign cmd_hdr_o.valid = (cnt_q != '0);
  assign cmd_hdr_o.op    = op_q[rd_ptr_q];
  assign cmd_id_o        = id_q[rd_ptr_q];
  assign cmd_prio_o      = prio_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == AW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // decode the opcode once on the way in
  always_ff @(posedge clk_i) begin
    if (push) begin
      op_q[wr_ptr_q]   <= op_e'(opcode_i);
      id_q[wr_ptr_q]   <= proc_id_i;
      prio_q[wr_ptr_q] <= proc_priority_i;
    end
  end

endmodule : rqd_front

`default_nettype wire

/* rtl/rqd_back.sv */
// Back end: sequencer that carries out requests on the ready queue memory and running slot.
// Holds the policy register and the result register. Depends on rqd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rqd_back #(
  parameter int unsigned QUEUE_DEPTH = rqd_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned ID_BITS     = rqd_pkg::ID_BITS_DEF,
  parameter int unsigned PRIO_BITS   = rqd_pkg::PRIO_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [1:0]           cfg_wdata_i,
  input  wire rqd_pkg::cmd_hdr_t    cmd_hdr_i,
  output logic                      cmd_ready_o,
  input  wire logic [ID_BITS-1:0]   cmd_id_i,
  input  wire logic [PRIO_BITS-1:0] cmd_prio_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [2:0]                status_o,
  output logic [ID_BITS-1:0]        chosen_id_o,
  output logic                      preempt_flag_o,
  output logic [ID_BITS-1:0]        preempt_id_o
);
  import rqd_pkg::*;

  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned EW = ID_BITS + PRIO_BITS;

  logic [EW-1:0] mem [QUEUE_DEPTH];
  logic [EW-1:0] rd_data_q;
  logic          mem_we, mem_re;
  logic [IW-1:0] mem_waddr, mem_raddr;
  logic [EW-1:0] mem_wdata;

  bk_state_e state_q, state_d;
  op_e       op_q, op_d;
  logic [1:0] mode_q;

  logic [CW-1:0]        count_q, count_d;
  logic                 run_valid_q, run_valid_d;
  logic [ID_BITS-1:0]   run_id_q, run_id_d;
  logic [PRIO_BITS-1:0] run_prio_q, run_prio_d;

  logic [CW-1:0]        ptr_q, ptr_d;
  logic [CW-1:0]        end_q, end_d;
  logic                 rd_vld_q, rd_vld_d;
  logic [CW-1:0]        rd_idx_q, rd_idx_d;
  logic [ID_BITS-1:0]   best_id_q, best_id_d;
  logic [PRIO_BITS-1:0] best_prio_q, best_prio_d;
  logic [CW-1:0]        best_idx_q, best_idx_d;

  logic                 out_valid_q, out_valid_d;
  status_e              status_q, status_d;
  logic [ID_BITS-1:0]   chosen_q, chosen_d;
  logic                 pflag_q, pflag_d;
  logic [ID_BITS-1:0]   pid_q, pid_d;

  logic                 start, issue, full, prio_mode, preempt;
  logic [ID_BITS-1:0]   rd_id;
  logic [PRIO_BITS-1:0] rd_prio;

  assign rd_id     = rd_data_q[EW-1:PRIO_BITS];
  assign rd_prio   = rd_data_q[PRIO_BITS-1:0];
  assign full      = (count_q == CW'(QUEUE_DEPTH));
  assign prio_mode = (mode_q == POLICY_PRIO);
  assign preempt   = (run_prio_q > best_prio_q);

  // take a request only when the result register will be free
  assign start       = cmd_hdr_i.valid && (state_q == BK_IDLE) && (!out_valid_q || out_ready_i);
  assign cmd_ready_o = start;

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign chosen_id_o    = chosen_q;
  assign preempt_flag_o = pflag_q;
  assign preempt_id_o   = pid_q;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    count_d     = count_q;
    run_valid_d = run_valid_q;
    run_id_d    = run_id_q;
    run_prio_d  = run_prio_q;
    ptr_d       = ptr_q;
    end_d       = end_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    best_id_d   = best_id_q;
    best_prio_d = best_prio_q;
    best_idx_d  = best_idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    chosen_d    = chosen_q;
    pflag_d     = pflag_q;
    pid_d       = pid_q;
    mem_we      = 1'b0;
    mem_waddr   = count_q[IW-1:0];
    mem_wdata   = {cmd_id_i, cmd_prio_i};
    mem_re      = 1'b0;
    mem_raddr   = ptr_q[IW-1:0];
    issue       = 1'b0;

    case (state_q)
      BK_IDLE: begin
        if (start) begin
          out_valid_d = 1'b1;
          status_d    = STAT_OK;
          chosen_d    = '0;
          pflag_d     = 1'b0;
          pid_d       = '0;
          op_d        = cmd_hdr_i.op;
          case (cmd_hdr_i.op)
            OP_ENQ: begin
              if (full) begin
                status_d = STAT_FULL;
              end else begin
                mem_we  = 1'b1;
                count_d = count_q + CW'(1);
                if (prio_mode && run_valid_q) begin
                  // hold the result until the best entry is known
                  out_valid_d = 1'b0;
                  ptr_d       = '0;
                  end_d       = count_q + CW'(1);
                  state_d     = BK_SCAN;
                end
              end
            end
            OP_DISP: begin
              if (run_valid_q) begin
                status_d = STAT_BUSY;
              end else if (count_q == '0) begin
                status_d = STAT_EMPTY;
              end else begin
                out_valid_d = 1'b0;
                ptr_d       = '0;
                end_d       = prio_mode ? count_q : CW'(1);
                state_d     = BK_SCAN;
              end
            end
            OP_REQUEUE: begin
              if (!run_valid_q) begin
                status_d = STAT_IDLE;
              end else if (full) begin
                status_d = STAT_FULL;
              end else begin
                mem_we      = 1'b1;
                mem_wdata   = {run_id_q, run_prio_q};
                count_d     = count_q + CW'(1);
                run_valid_d = 1'b0;
                chosen_d    = run_id_q;
              end
            end
            default: begin
              if (!run_valid_q) begin
                status_d = STAT_IDLE;
              end else begin
                run_valid_d = 1'b0;
                chosen_d    = run_id_q;
              end
            end
          endcase
        end
      end

      BK_SCAN: begin
        issue     = (ptr_q < end_q);
        mem_re    = issue;
        rd_vld_d  = issue;
        rd_idx_d  = ptr_q;
        if (issue) begin
          ptr_d = ptr_q + CW'(1);
        end
        // earliest entry wins a tie
        if (rd_vld_q && ((rd_idx_q == '0) || (best_prio_q > rd_prio))) begin
          best_id_d   = rd_id;
          best_prio_d = rd_prio;
          best_idx_d  = rd_idx_q;
        end
        if (!issue && !rd_vld_q) begin
          if (op_q == OP_ENQ) begin
            out_valid_d = 1'b1;
            pflag_d     = preempt;
            pid_d       = preempt ? best_id_q : '0;
            state_d     = BK_IDLE;
          end else begin
            run_valid_d = 1'b1;
            run_id_d    = best_id_q;
            run_prio_d  = best_prio_q;
            ptr_d       = best_idx_q + CW'(1);
            state_d     = BK_COMPACT;
          end
        end
      end

      BK_COMPACT: begin
        // move each entry above the removed one down by one slot
        issue     = (ptr_q < count_q);
        mem_re    = issue;
        rd_vld_d  = issue;
        rd_idx_d  = ptr_q;
        if (issue) begin
          ptr_d = ptr_q + CW'(1);
        end
        if (rd_vld_q) begin
          mem_we    = 1'b1;
          mem_waddr = IW'(rd_idx_q - CW'(1));
          mem_wdata = rd_data_q;
        end
        if (!issue && !rd_vld_q) begin
          count_d     = count_q - CW'(1);
          out_valid_d = 1'b1;
          chosen_d    = run_id_q;
          state_d     = BK_IDLE;
        end
      end

      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      mode_q      <= POLICY_FIFO;
      count_q     <= '0;
      run_valid_q <= 1'b0;
      run_id_q    <= '0;
      run_prio_q  <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      count_q     <= count_d;
      run_valid_q <= run_valid_d;
      run_id_q    <= run_id_d;
      run_prio_q  <= run_prio_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    ptr_q       <= ptr_d;
    end_q       <= end_d;
    rd_idx_q    <= rd_idx_d;
    best_id_q   <= best_id_d;
    best_prio_q <= best_prio_d;
    best_idx_q  <= best_idx_d;
    status_q    <= status_d;
    chosen_q    <= chosen_d;
    pflag_q     <= pflag_d;
    pid_q       <= pid_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_raddr];
    end
  end

endmodule : rqd_back

`default_nettype wire

/* rtl/ready_queue_dispatcher_core.sv */
// Top level of the ready queue dispatcher: request front end, request queue and back end.
// Depends on rqd_pkg, rqd_front and rqd_back.
//
//   port group    direction  handshake              payload
//   request       in         in_valid_i/in_ready_o  opcode_i, proc_id_i, proc_priority_i
//   result        out        out_valid_o/out_ready_i status_o, chosen_id_o,
//                                                   preempt_flag_o, preempt_id_o
//   policy reg    in         cfg_we_i               cfg_wdata_i
//
// A request waits in the front queue until the back sequencer takes it and runs it.
// Requeue, retire, fast-path cases and enqueue outside priority mode finish in BK_IDLE.
// Enqueue in priority mode with a process running scans all N queued entries, the new one
// included, one memory read per entry. Dispatch scans S entries (S = N in priority mode,
// else 1) and then compacts the entries above removed slot k (head is slot 0) down by one,
// one entry a cycle; nothing moves when the removed slot is the tail.
// Reset clears the counts and the running slot at once; queue memory needs no clearing.
// The front keeps taking requests while the back is busy or a result waits, until its queue is full.
`timescale 1ns / 1ps
`default_nettype none

module ready_queue_dispatcher_core #(
  parameter int unsigned QUEUE_DEPTH = rqd_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned ID_BITS     = rqd_pkg::ID_BITS_DEF,
  parameter int unsigned PRIO_BITS   = rqd_pkg::PRIO_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [1:0]           cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [1:0]           opcode_i,
  input  wire logic [ID_BITS-1:0]   proc_id_i,
  input  wire logic [PRIO_BITS-1:0] proc_priority_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [2:0]                status_o,
  output logic [ID_BITS-1:0]        chosen_id_o,
  output logic                      preempt_flag_o,
  output logic [ID_BITS-1:0]        preempt_id_o
);
  import rqd_pkg::*;

  cmd_hdr_t             cmd_hdr;
  logic                 cmd_ready;
  logic [ID_BITS-1:0]   cmd_id;
  logic [PRIO_BITS-1:0] cmd_prio;

  rqd_front #(
    .ID_BITS   (ID_BITS),
    .PRIO_BITS (PRIO_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .proc_id_i       (proc_id_i),
    .proc_priority_i (proc_priority_i),
    .cmd_hdr_o       (cmd_hdr),
    .cmd_ready_i     (cmd_ready),
    .cmd_id_o        (cmd_id),
    .cmd_prio_o      (cmd_prio)
  );

  rqd_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS),
    .PRIO_BITS   (PRIO_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_hdr_i      (cmd_hdr),
    .cmd_ready_o    (cmd_ready),
    .cmd_id_i       (cmd_id),
    .cmd_prio_i     (cmd_prio),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .chosen_id_o    (chosen_id_o),
    .preempt_flag_o (preempt_flag_o),
    .preempt_id_o   (preempt_id_o)
  );

  // the back starts a request only when the result register is free or draining
  a_start_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_hdr.valid && cmd_ready) |-> (!out_valid_o || out_ready_i))
    else $error("request started while a result was stuck");

  // a failed request never names a process
  a_fail_no_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != STAT_OK)) |-> ((chosen_id_o == '0) && !preempt_flag_o))
    else $error("failed request carries an id or preemption");

  // preemption only comes from an enqueue, which names no chosen process
  a_preempt_enq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && preempt_flag_o) |-> (chosen_id_o == '0))
    else $error("preemption together with a chosen id");

  a_no_preempt_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !preempt_flag_o) |-> (preempt_id_o == '0))
    else $error("preempt id without preemption");

endmodule : ready_queue_dispatcher_core

`default_nettype wire
